@@ rtl/sirt_pkg.sv @@
// sirt_pkg: shared constants, register indexes and control/status structs
// for the signed integer to radix text block
// no dependencies
`default_nettype none

package sirt_pkg;

	localparam int VAL_W      = 32;
	localparam int SYM_W      = 8;
	localparam int MAX_RADIX  = 16;
	localparam int MAX_DIGITS = 32;
	localparam int DIG_W      = $clog2(MAX_RADIX);
	localparam int ADDR_W     = $clog2(MAX_DIGITS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int RADIX_W    = DIG_W + 1;
	localparam int BIT_W      = $clog2(VAL_W);
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int SYMS_W     = MAX_RADIX * SYM_W;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

	localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;

	// controller to datapath
	typedef struct packed {
		logic load;       // latch value, clear digit count
		logic div_step;   // one restoring division step
		logic push;       // store remainder digit, next digit
		logic sign;       // emit minus if negative, set read pointer
		logic rd;         // read digit store
		logic emit;       // emit symbol of read digit
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic quot_zero;
		logic store_full;
		logic k_one;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/sirt_cfg.sv @@
// sirt_cfg: configuration registers and registered alphabet validity check
// depends on sirt_pkg
`default_nettype none

module sirt_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic [sirt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sirt_pkg::CFG_W-1:0]      cfg_data,
	output logic      [sirt_pkg::RADIX_W-1:0]    radix,
	output logic      [sirt_pkg::SYMS_W-1:0]     symbols,
	output logic                                 alpha_ok
);

	logic [sirt_pkg::RADIX_W-1:0] radix_q;
	logic [sirt_pkg::CFG_W-1:0]   sym_lo_q;
	logic [sirt_pkg::CFG_W-1:0]   sym_hi_q;
	logic                         ok_q;
	logic                         ok_d;
	logic [sirt_pkg::SYMS_W-1:0]  syms;

	assign syms = {sym_hi_q, sym_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= '0;
			sym_lo_q <= '0;
			sym_hi_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sirt_pkg::REG_RADIX_SIZE:   radix_q  <= cfg_data[sirt_pkg::RADIX_W-1:0];
				sirt_pkg::REG_SYMBOLS_LOW:  sym_lo_q <= cfg_data;
				sirt_pkg::REG_SYMBOLS_HIGH: sym_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// symbols beyond the radix are ignored
	always_comb begin
		logic [sirt_pkg::SYM_W-1:0] si;
		logic [sirt_pkg::SYM_W-1:0] sj;
		logic                       bad;
		bad = (radix_q < sirt_pkg::RADIX_W'(2)) ||
			(radix_q > sirt_pkg::RADIX_W'(sirt_pkg::MAX_RADIX));
		for (int i = 0; i < sirt_pkg::MAX_RADIX; i++) begin
			si = syms[i*sirt_pkg::SYM_W +: sirt_pkg::SYM_W];
			if (sirt_pkg::RADIX_W'(i) < radix_q) begin
				if (si == sirt_pkg::CHAR_NUL || si == sirt_pkg::CHAR_PLUS ||
					si == sirt_pkg::CHAR_MINUS)
					bad = 1'b1;
			end
			for (int j = i + 1; j < sirt_pkg::MAX_RADIX; j++) begin
				sj = syms[j*sirt_pkg::SYM_W +: sirt_pkg::SYM_W];
				if (sirt_pkg::RADIX_W'(j) < radix_q && si == sj)
					bad = 1'b1;
			end
		end
		ok_d = !bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else begin
			ok_q <= ok_d;
		end
	end

	assign radix    = radix_q;
	assign symbols  = syms;
	assign alpha_ok = ok_q;

endmodule

`default_nettype wire

@@ rtl/sirt_ctrl.sv @@
// sirt_ctrl: sequencer for check, bit-serial division per digit and emission
// depends on sirt_pkg
`default_nettype none

module sirt_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                alpha_ok,
	input  wire sirt_pkg::sts_t      sts,
	output logic                     busy,
	output sirt_pkg::cmd_t           cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_PUSH,
		ST_SIGN,
		ST_RD,
		ST_EMIT
	} state_t;

	state_t                     state_q;
	logic [sirt_pkg::BIT_W-1:0] bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					bit_q <= '0;
					if (start) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= alpha_ok ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == '1) state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					state_q <= (sts.quot_zero || sts.store_full) ? ST_SIGN : ST_DIV;
				end
				ST_SIGN: state_q <= ST_RD;
				ST_RD:   state_q <= ST_EMIT;
				ST_EMIT: begin
					state_q <= sts.k_one ? ST_IDLE : ST_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && start;
		cmd.div_step = (state_q == ST_DIV);
		cmd.push     = (state_q == ST_PUSH);
		cmd.sign     = (state_q == ST_SIGN);
		cmd.rd       = (state_q == ST_RD);
		cmd.emit     = (state_q == ST_EMIT);
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/sirt_dp.sv @@
// sirt_dp: magnitude/quotient register, radix divider, digit store, output registers
// depends on sirt_pkg
`default_nettype none

module sirt_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sirt_pkg::cmd_t                 cmd,
	input  wire logic signed [sirt_pkg::VAL_W-1:0] value,
	input  wire logic [sirt_pkg::RADIX_W-1:0]   radix,
	input  wire logic [sirt_pkg::SYMS_W-1:0]    symbols,
	output sirt_pkg::sts_t                      sts,
	output logic                                strobe,
	output logic [sirt_pkg::SYM_W-1:0]          character,
	output logic                                last
);

	logic [sirt_pkg::VAL_W-1:0]   mag_q;      // magnitude, then quotient
	logic [sirt_pkg::DIG_W-1:0]   rem_q;
	logic [sirt_pkg::CNT_W-1:0]   count_q;
	logic [sirt_pkg::CNT_W-1:0]   k_q;
	logic                         neg_q;
	logic [sirt_pkg::DIG_W-1:0]   rdata_q;
	logic                         strobe_q;
	logic [sirt_pkg::SYM_W-1:0]   char_q;
	logic                         last_q;
	logic [sirt_pkg::DIG_W-1:0]   store [sirt_pkg::MAX_DIGITS];

	logic [sirt_pkg::RADIX_W-1:0] partial;
	logic                         ge;
	logic [sirt_pkg::RADIX_W-1:0] diff;
	logic [sirt_pkg::CNT_W-1:0]   k_m1;
	logic [sirt_pkg::VAL_W-1:0]   uval;

	assign uval    = sirt_pkg::VAL_W'(value);
	assign partial = {rem_q, mag_q[sirt_pkg::VAL_W-1]};
	assign ge      = (partial >= radix);
	assign diff    = partial - radix;
	assign k_m1    = k_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			k_q      <= '0;
			neg_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.sign && neg_q) || cmd.emit;
			if (cmd.load) begin
				count_q <= '0;
				neg_q   <= value[sirt_pkg::VAL_W-1];
			end
			if (cmd.push) count_q <= count_q + 1'b1;
			if (cmd.sign) k_q <= count_q;
			if (cmd.emit) k_q <= k_m1;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= value[sirt_pkg::VAL_W-1] ? (sirt_pkg::VAL_W'(0) - uval) : uval;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			// restoring step: shift in next dividend bit, quotient bit out at the bottom
			rem_q <= ge ? diff[sirt_pkg::DIG_W-1:0] : partial[sirt_pkg::DIG_W-1:0];
			mag_q <= {mag_q[sirt_pkg::VAL_W-2:0], ge};
		end
		if (cmd.push) begin
			store[count_q[sirt_pkg::ADDR_W-1:0]] <= rem_q;
			rem_q <= '0;
		end
		if (cmd.rd) rdata_q <= store[k_m1[sirt_pkg::ADDR_W-1:0]];
		if (cmd.sign) begin
			char_q <= sirt_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end
		if (cmd.emit) begin
			char_q <= symbols[{rdata_q, 3'b000} +: sirt_pkg::SYM_W];
			last_q <= (k_q == sirt_pkg::CNT_W'(1));
		end
	end

	assign sts.quot_zero  = (mag_q == '0);
	assign sts.store_full = (count_q == sirt_pkg::CNT_W'(sirt_pkg::MAX_DIGITS - 1));
	assign sts.k_one      = (k_q == sirt_pkg::CNT_W'(1));

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	a_emit_has_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> k_q != '0)
		else $error("digit emitted with empty read pointer");
	a_push_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !count_q[sirt_pkg::CNT_W-1])
		else $error("digit store overflow");
	a_final_char_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.k_one) |=> (strobe && last))
		else $error("final digit not marked last");
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sign && neg_q) |=> (strobe && !last && character == sirt_pkg::CHAR_MINUS))
		else $error("minus sign transfer wrong");
`endif

endmodule

`default_nettype wire

@@ rtl/signed_integer_to_radix_text_top.sv @@
// signed_integer_to_radix_text_top: top level of the signed integer to radix text block
// depends on sirt_pkg, sirt_cfg, sirt_ctrl, sirt_dp
//
// usage:
//  - configuration: cfg_valid/cfg_ready with cfg_index (0 radix size, 1 symbols 0..7,
//    2 symbols 8..15) and cfg_data; cfg_ready is always high, index 3 is ignored.
//    write only while busy is low.
//  - input: value is taken at an edge with start high and busy low.
//  - results: one character per cycle in which strobe is high, last marks the final
//    character; the receiver cannot stall, every strobe is a transfer.
//  - sequence: a check, then per digit a 32-step bit-serial division
//    plus one store write, then the sign, then per character a digit store read
//    and a symbol lookup. radix 2 with -2^31 gives the longest text, a minus and 32 digits.
//  - an invalid alphabet gives no characters; busy drops after the check state.
//  - the last strobe falls in the first cycle with busy low; a new start is taken at
//    the edge that ends it.
//  - reset clears configuration to zero (alphabet invalid) and returns to idle;
//    the digit store is not cleared.
`default_nettype none

module signed_integer_to_radix_text_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [sirt_pkg::VAL_W-1:0]   value,
	output logic                                     strobe,
	output logic      [sirt_pkg::SYM_W-1:0]          character,
	output logic                                     last,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [sirt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sirt_pkg::CFG_W-1:0]          cfg_data
);

	logic [sirt_pkg::RADIX_W-1:0] radix;
	logic [sirt_pkg::SYMS_W-1:0]  symbols;
	logic                         alpha_ok;
	sirt_pkg::cmd_t               cmd;
	sirt_pkg::sts_t               sts;

	assign cfg_ready = 1'b1;

	sirt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.radix     (radix),
		.symbols   (symbols),
		.alpha_ok  (alpha_ok)
	);

	sirt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.alpha_ok (alpha_ok),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	sirt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (value),
		.radix     (radix),
		.symbols   (symbols),
		.sts       (sts),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking testbench for signed_integer_to_radix_text_top
// predicts the text of every accepted value and checks each strobed character
// depends on sirt_pkg and the rtl of the block

typedef struct packed {
	logic [7:0] character;
	logic       last;
} text_char_t;

class radix_text_scoreboard;
	logic [4:0]   radix_size;
	logic [127:0] symbols;
	logic [31:0]  magnitude;
	logic [3:0]   digits [32];
	int unsigned  digit_count;
	logic         negative;
	text_char_t   pending [$];
	int           errors;

	function new();
		radix_size  = '0;
		symbols     = '0;
		magnitude   = '0;
		digit_count = 0;
		negative    = 1'b0;
		errors      = 0;
	endfunction

	function logic [7:0] symbol(int unsigned i);
		return symbols[8*i +: 8];
	endfunction

	function bit alphabet_valid();
		int unsigned n;
		logic [7:0] s;
		n = radix_size;
		if (n < 2 || n > sirt_pkg::MAX_RADIX)
			return 1'b0;
		for (int unsigned i = 0; i < n; i++) begin
			s = symbol(i);
			if (s == sirt_pkg::CHAR_NUL || s == sirt_pkg::CHAR_PLUS || s == sirt_pkg::CHAR_MINUS)
				return 1'b0;
			for (int unsigned j = i + 1; j < n; j++)
				if (symbol(j) == s)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	function void write_reg(logic [1:0] idx, logic [63:0] data);
		case (idx)
			sirt_pkg::REG_RADIX_SIZE:   radix_size = data[4:0];
			sirt_pkg::REG_SYMBOLS_LOW:  symbols[63:0] = data;
			sirt_pkg::REG_SYMBOLS_HIGH: symbols[127:64] = data;
			default: ;
		endcase
	endfunction

	// digits are produced least significant first and emitted in reverse
	function void note_value(logic [31:0] v);
		int unsigned n;
		logic [31:0] rest;
		n = radix_size;
		if (!alphabet_valid())
			return;
		negative    = v[31];
		magnitude   = negative ? 32'd0 - v : v;
		digit_count = 0;
		rest        = magnitude;
		do begin
			digits[digit_count] = 4'(rest % n);
			rest = rest / n;
			digit_count++;
		end while (rest != 0 && digit_count < sirt_pkg::MAX_DIGITS);
		if (negative)
			pending.push_back('{character: sirt_pkg::CHAR_MINUS, last: 1'b0});
		for (int unsigned k = digit_count; k > 0; k--)
			pending.push_back('{character: symbol(digits[k-1]), last: (k == 1)});
	endfunction

	function void report(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	function void check_char(logic [7:0] c, logic l);
		text_char_t want;
		if (pending.size() == 0) begin
			report($sformatf("unexpected character %h last %b", c, l));
			return;
		end
		want = pending.pop_front();
		if (want.character !== c || want.last !== l)
			report($sformatf("mismatch: character %h last %b, wanted character %h last %b",
				c, l, want.character, want.last));
	endfunction
endclass

module tb;

	localparam logic [1:0]  REG_UNUSED     = 2'd3;
	localparam int          WATCHDOG_LIMIT = 20000;
	localparam int          TAIL_CYCLES    = 1200;
	localparam int          TARGET_ITEMS   = 245;
	localparam int          QUIET_AFTER    = 220;
	localparam logic [31:0] INT_MIN        = 32'h8000_0000;
	localparam logic [31:0] INT_MAX        = 32'h7FFF_FFFF;
	localparam logic [63:0] DEC_LOW        = 64'h3736_3534_3332_3130;
	localparam logic [63:0] DEC_HIGH       = 64'h0000_0000_0000_3938;
	localparam logic [63:0] HEX_HIGH       = 64'h4645_4443_4241_3938;
	localparam logic [63:0] ODD_LOW        = 64'h80FF_7F01_AA55_C3E1;
	localparam logic [63:0] ODD_HIGH       = 64'h1F2E_3C4B_5A69_7887;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic signed [31:0] value = '0;
	logic        strobe;
	logic [7:0]  character;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	bit          quiet = 1'b0;
	int          idle_cycles = 0;

	radix_text_scoreboard board = new();

	signed_integer_to_radix_text_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.character (character),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// sample everything on the edge that accepts it
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				board.check_char(character, last);
			if (start && !busy)
				board.note_value(value);
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
			if (strobe || (start && !busy) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send_value(input logic [31:0] v);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
		if (!quiet && $urandom_range(0, 2) == 0) begin
			cfg_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// all text out, then let a possible check state of an ignored value pass
	task automatic settle();
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic configure(input logic [4:0] radix, input logic [63:0] low,
		input logic [63:0] high);
		logic [63:0] radix_word;
		settle();
		radix_word      = {$urandom, $urandom};
		radix_word[4:0] = radix;
		if ($urandom_range(0, 4) == 0)
			cfg_write(REG_UNUSED, {$urandom, $urandom});
		cfg_write(sirt_pkg::REG_RADIX_SIZE, radix_word);
		cfg_write(sirt_pkg::REG_SYMBOLS_LOW, low);
		cfg_write(sirt_pkg::REG_SYMBOLS_HIGH, high);
		cfg_valid <= 1'b0;
	endtask

	// distinct legal symbols in use, garbage beyond the radix, sometimes broken
	task automatic random_alphabet(output bit usable);
		logic [127:0] syms;
		logic [255:0] taken;
		logic [7:0]   b;
		logic [4:0]   radix;
		int           n;
		int           pos;
		int           other;
		case ($urandom_range(0, 9))
			0:       n = 2;
			1:       n = 16;
			default: n = $urandom_range(2, 16);
		endcase
		taken = '0;
		taken[sirt_pkg::CHAR_NUL]   = 1'b1;
		taken[sirt_pkg::CHAR_PLUS]  = 1'b1;
		taken[sirt_pkg::CHAR_MINUS] = 1'b1;
		for (int i = 0; i < 16; i++) begin
			if (i < n) begin
				do b = 8'($urandom_range(1, 255)); while (taken[b]);
				taken[b] = 1'b1;
			end else begin
				b = 8'($urandom);
			end
			syms[8*i +: 8] = b;
		end
		radix  = 5'(n);
		usable = 1'b1;
		if ($urandom_range(0, 4) == 0) begin
			usable = 1'b0;
			pos    = $urandom_range(0, n - 1);
			case ($urandom_range(0, 5))
				0: radix = 5'($urandom_range(0, 1));
				1: radix = 5'($urandom_range(17, 31));
				2: begin
					pos   = $urandom_range(1, n - 1);
					other = $urandom_range(0, pos - 1);
					syms[8*pos +: 8] = syms[8*other +: 8];
				end
				3: syms[8*pos +: 8] = sirt_pkg::CHAR_PLUS;
				4: syms[8*pos +: 8] = sirt_pkg::CHAR_MINUS;
				default: syms[8*pos +: 8] = sirt_pkg::CHAR_NUL;
			endcase
		end
		configure(radix, syms[63:0], syms[127:64]);
	endtask

	function automatic logic [31:0] pick_value(int n);
		longint      p;
		int          k;
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0: v = $urandom;
			1: v = $urandom_range(0, 300);
			2: v = 32'd0 - 32'($urandom_range(1, 300));
			3: begin
				case ($urandom_range(0, 4))
					0:       v = INT_MIN;
					1:       v = INT_MAX;
					2:       v = '0;
					3:       v = '1;
					default: v = 32'd1;
				endcase
			end
			4: begin
				// around a power of the radix, where the digit count steps
				p = 1;
				k = $urandom_range(1, 31);
				while (k > 0 && p * n <= longint'(INT_MAX)) begin
					p = p * n;
					k--;
				end
				v = 32'(p - $urandom_range(0, 1));
				if ($urandom_range(0, 1) == 1)
					v = 32'd0 - v;
			end
			default: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1) == 1)
					v = 32'd0 - v;
			end
		endcase
		return v;
	endfunction

	initial begin
		int valid_items;
		int count;
		bit usable;
		valid_items = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// alphabet cleared by reset, nothing comes out
		send_value(32'd12345);

		configure(5'd10, DEC_LOW, DEC_HIGH);
		send_value(32'd0);
		send_value(32'd9);
		send_value(32'd10);
		send_value('1);
		send_value(INT_MAX);
		send_value(INT_MIN);
		send_value(32'hFFF0_BDC0);

		// binary, unused bytes hold duplicates, zero, plus and minus
		configure(5'd2, 64'h2D2B_0031_3131_3130, {$urandom, $urandom});
		send_value(INT_MIN);
		send_value(INT_MAX);
		send_value(32'd0);

		configure(5'd16, ODD_LOW, ODD_HIGH);
		send_value('1);
		send_value(32'h89AB_CDEF);

		// broken alphabets
		configure(5'd1, DEC_LOW, DEC_HIGH);
		send_value(32'd7);
		configure(5'd17, DEC_LOW, HEX_HIGH);
		send_value(32'd7);
		configure(5'd10, DEC_LOW, 64'h3930);
		send_value(32'd7);
		configure(5'd10, DEC_LOW, 64'h2B38);
		send_value(32'd7);
		configure(5'd3, 64'h2D3130, '0);
		send_value(32'd7);
		configure(5'd4, 64'h0032_3130, '0);
		send_value(32'd7);

		// a write to the unused index changes nothing
		configure(5'd16, DEC_LOW, HEX_HIGH);
		settle();
		cfg_write(REG_UNUSED, '1);
		cfg_valid <= 1'b0;
		send_value(INT_MIN);

		while (valid_items < TARGET_ITEMS) begin
			quiet = (valid_items >= QUIET_AFTER);
			random_alphabet(usable);
			count = usable ? $urandom_range(5, 25) : 3;
			repeat (count) begin
				quiet = (valid_items >= QUIET_AFTER);
				send_value(pick_value(board.radix_size));
				if (usable)
					valid_items++;
			end
		end

		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
